@@ design/alfl_pkg.sv @@
// ----------------------------------------------------------------------------
// alfl_pkg: shared types and constants for the positional list
// Command and status codes, the per-cell operation code, the control bundle
// that the sequencer broadcasts along the row of cells, and sequencer states.
// ----------------------------------------------------------------------------
package alfl_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int IDX_WIDTH_DEF  = $clog2(CAPACITY_DEF + 1);
    localparam int CMD_WIDTH      = 4;
    localparam int STATUS_WIDTH   = 2;

    typedef enum logic [CMD_WIDTH-1:0] {
        CMD_INSERT     = 4'd0,
        CMD_PUSH_BACK  = 4'd1,
        CMD_PUSH_FRONT = 4'd2,
        CMD_POP_FRONT  = 4'd3,
        CMD_POP_BACK   = 4'd4,
        CMD_REMOVE     = 4'd5,
        CMD_REPLACE    = 4'd6,
        CMD_READ       = 4'd7,
        CMD_CLEAR      = 4'd8
    } cmd_t;

    typedef enum logic [STATUS_WIDTH-1:0] {
        STS_OK    = 2'd0,
        STS_RANGE = 2'd1,
        STS_EMPTY = 2'd2,
        STS_FULL  = 2'd3
    } status_t;

    // What every cell does in the cycle the command is applied.
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE,
        OP_WRITE,
        OP_CLEAR
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     capture;
        logic     shift;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_APPLY,
        S_WALK,
        S_DONE
    } ctrl_state_t;

endpackage

@@ design/alfl_req_if.sv @@
// ----------------------------------------------------------------------------
// alfl_req_if: command channel of the positional list
// Valid/ready channel carrying one command, its position and its element.
// ----------------------------------------------------------------------------
interface alfl_req_if #(
    parameter int DATA_WIDTH = alfl_pkg::DATA_WIDTH_DEF,
    parameter int POS_WIDTH  = alfl_pkg::IDX_WIDTH_DEF
);
    import alfl_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [CMD_WIDTH-1:0]          cmd;
    logic [POS_WIDTH-1:0]          position;
    logic signed [DATA_WIDTH-1:0]  value_in;

    modport source (output valid, output cmd, output position, output value_in,
                    input ready);
    modport sink   (input valid, input cmd, input position, input value_in,
                    output ready);
endinterface

@@ design/alfl_rsp_if.sv @@
// ----------------------------------------------------------------------------
// alfl_rsp_if: response channel of the positional list
// Valid/ready channel carrying the element, the status and the new count.
// ----------------------------------------------------------------------------
interface alfl_rsp_if #(
    parameter int DATA_WIDTH  = alfl_pkg::DATA_WIDTH_DEF,
    parameter int COUNT_WIDTH = alfl_pkg::IDX_WIDTH_DEF
);
    import alfl_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [DATA_WIDTH-1:0]  value_out;
    logic [STATUS_WIDTH-1:0]       status;
    logic [COUNT_WIDTH-1:0]        count;

    modport source (output valid, output value_out, output status, output count,
                    input ready);
    modport sink   (input valid, input value_out, input status, input count,
                    output ready);
endinterface

@@ design/array_linked_list_with_free_list.sv @@
// ----------------------------------------------------------------------------
// array_linked_list_with_free_list: positional list of signed words
// Top level: command sequencer plus a row of CAPACITY element cells.
// ----------------------------------------------------------------------------
// The block keeps an ordered list of up to CAPACITY signed words and takes
// one command transaction at a time on req: insert, push at either end, pop
// at either end, remove, replace, read at a position, or clear. Each command
// gives exactly one response transaction on rsp with the element taken out,
// replaced (old value) or read, a status (ok, position out of range, list
// empty, list full) and the element count afterwards; the element is zero
// for every other command and for every failed one. Positions are zero
// based; an insert may name the position just past the last element.
// Storage is a row of cells, one per list position. A command is checked in
// the cycle it is accepted and applied to all cells in the next cycle, where
// every cell behind the insertion or removal point takes its neighbor's
// element. An element that is returned is then walked cell by cell toward
// the head of the row, one cell per cycle, so an element further from the
// head takes longer to come back (a pop from the back reads position
// count - 1). A new command is taken once the previous response is held
// in the output register, whether or not the consumer has collected it
// yet. There is no clearing pass: reset empties the list at once.
// ----------------------------------------------------------------------------
module array_linked_list_with_free_list #(
    parameter int CAPACITY   = alfl_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = alfl_pkg::DATA_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    alfl_req_if.sink    req,
    alfl_rsp_if.source  rsp
);
    import alfl_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY + 1);

    cell_ctl_t                    ctl;
    logic [IDX_W-1:0]             tgt;
    logic signed [DATA_WIDTH-1:0] wr_value;
    logic signed [DATA_WIDTH-1:0] cell_value [CAPACITY];
    logic signed [DATA_WIDTH-1:0] cell_rd    [CAPACITY];

    alfl_ctrl #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .rd_head  (cell_rd[0]),
        .ctl      (ctl),
        .tgt      (tgt),
        .wr_value (wr_value)
    );

    // Each cell sees only its two neighbors. The first cell never takes from
    // the left and the last cell's right side reads as zero, which is what
    // a removal leaves behind past the end of the list.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [DATA_WIDTH-1:0] left_w;
        logic signed [DATA_WIDTH-1:0] right_w;
        logic signed [DATA_WIDTH-1:0] right_rd_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_inner_left
            assign left_w = cell_value[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_w    = '0;
            assign right_rd_w = '0;
        end
        else
        begin : g_inner_right
            assign right_w    = cell_value[i+1];
            assign right_rd_w = cell_rd[i+1];
        end

        alfl_cell #(
            .INDEX      (i),
            .IDX_W      (IDX_W),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .tgt         (tgt),
            .wr_value    (wr_value),
            .left_value  (left_w),
            .right_value (right_w),
            .right_rd    (right_rd_w),
            .value       (cell_value[i]),
            .rd          (cell_rd[i])
        );
    end

endmodule

@@ design/alfl_cell.sv @@
// ----------------------------------------------------------------------------
// alfl_cell: one list position
// Holds the element at a fixed position and one stage of the readout chain.
// ----------------------------------------------------------------------------
module alfl_cell #(
    parameter int INDEX      = 0,
    parameter int IDX_W      = alfl_pkg::IDX_WIDTH_DEF,
    parameter int DATA_WIDTH = alfl_pkg::DATA_WIDTH_DEF
) (
    input  logic                          clk,
    input  alfl_pkg::cell_ctl_t           ctl,
    input  logic [IDX_W-1:0]              tgt,
    input  logic signed [DATA_WIDTH-1:0]  wr_value,
    input  logic signed [DATA_WIDTH-1:0]  left_value,
    input  logic signed [DATA_WIDTH-1:0]  right_value,
    input  logic signed [DATA_WIDTH-1:0]  right_rd,
    output logic signed [DATA_WIDTH-1:0]  value,
    output logic signed [DATA_WIDTH-1:0]  rd
);
    import alfl_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic signed [DATA_WIDTH-1:0] val_reg, val_next;
    logic signed [DATA_WIDTH-1:0] rd_reg, rd_next;
    logic                         hit;
    logic                         above;

    assign hit   = (tgt == MY_IDX);
    assign above = (MY_IDX > tgt);

    always_comb
    begin
        val_next = val_reg;
        case (ctl.op)
            OP_INSERT:
            begin
                if (hit)
                    val_next = wr_value;
                else if (above)
                    val_next = left_value;
            end
            OP_REMOVE:
            begin
                if (hit || above)
                    val_next = right_value;
            end
            OP_WRITE:
            begin
                if (hit)
                    val_next = wr_value;
            end
            default:
            begin
                val_next = val_reg;
            end
        endcase
    end

    // The addressed cell drops its old element into the readout chain, which
    // then moves one cell toward the head per cycle.
    always_comb
    begin
        if (ctl.capture)
            rd_next = hit ? val_reg : '0;
        else if (ctl.shift)
            rd_next = right_rd;
        else
            rd_next = rd_reg;
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        rd_reg  <= rd_next;
    end

    assign value = val_reg;
    assign rd    = rd_reg;

endmodule

@@ design/alfl_ctrl.sv @@
// ----------------------------------------------------------------------------
// alfl_ctrl: command sequencer of the positional list
// Checks each command against the count, drives the row of cells, times the
// readout walk and holds the response register.
// ----------------------------------------------------------------------------
module alfl_ctrl #(
    parameter int CAPACITY   = alfl_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = alfl_pkg::DATA_WIDTH_DEF,
    parameter int IDX_W      = $clog2(CAPACITY + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    alfl_req_if.sink                      req,
    alfl_rsp_if.source                    rsp,
    input  logic signed [DATA_WIDTH-1:0]  rd_head,
    output alfl_pkg::cell_ctl_t           ctl,
    output logic [IDX_W-1:0]              tgt,
    output logic signed [DATA_WIDTH-1:0]  wr_value
);
    import alfl_pkg::*;

    localparam logic [IDX_W-1:0] CAP_IDX = IDX_W'(CAPACITY);

    ctrl_state_t                  state_reg, state_next;
    logic [IDX_W-1:0]             count_reg, count_next;
    logic [IDX_W-1:0]             walk_reg, walk_next;
    logic                         rsp_valid_reg, rsp_valid_next;

    cell_op_t                     op_reg;
    status_t                      status_reg;
    logic [IDX_W-1:0]             tgt_reg;
    logic signed [DATA_WIDTH-1:0] value_reg;
    logic                         read_reg;

    logic signed [DATA_WIDTH-1:0] rsp_value_reg;
    logic [STATUS_WIDTH-1:0]      rsp_status_reg;
    logic [IDX_W-1:0]             rsp_count_reg;

    cell_op_t                     dec_op;
    status_t                      dec_status;
    logic [IDX_W-1:0]             dec_tgt;
    logic                         dec_read;
    logic                         full;
    logic                         empty;
    logic                         accept;
    logic                         load_rsp;

    assign full   = (count_reg == CAP_IDX);
    assign empty  = (count_reg == '0);
    assign accept = req.valid && req.ready;

    // Command decode against the current count.
    always_comb
    begin
        dec_op     = OP_HOLD;
        dec_status = STS_OK;
        dec_tgt    = '0;
        dec_read   = 1'b0;
        case (cmd_t'(req.cmd))
            CMD_INSERT:
            begin
                if (req.position > count_reg)
                    dec_status = STS_RANGE;
                else if (full)
                    dec_status = STS_FULL;
                else
                begin
                    dec_op  = OP_INSERT;
                    dec_tgt = req.position;
                end
            end
            CMD_PUSH_BACK:
            begin
                if (full)
                    dec_status = STS_FULL;
                else
                begin
                    dec_op  = OP_INSERT;
                    dec_tgt = count_reg;
                end
            end
            CMD_PUSH_FRONT:
            begin
                if (full)
                    dec_status = STS_FULL;
                else
                    dec_op = OP_INSERT;
            end
            CMD_POP_FRONT:
            begin
                if (empty)
                    dec_status = STS_EMPTY;
                else
                begin
                    dec_op   = OP_REMOVE;
                    dec_read = 1'b1;
                end
            end
            CMD_POP_BACK:
            begin
                if (empty)
                    dec_status = STS_EMPTY;
                else
                begin
                    dec_op   = OP_REMOVE;
                    dec_tgt  = count_reg - 1'b1;
                    dec_read = 1'b1;
                end
            end
            CMD_REMOVE:
            begin
                if (req.position >= count_reg)
                    dec_status = STS_RANGE;
                else
                begin
                    dec_op   = OP_REMOVE;
                    dec_tgt  = req.position;
                    dec_read = 1'b1;
                end
            end
            CMD_REPLACE:
            begin
                if (req.position >= count_reg)
                    dec_status = STS_RANGE;
                else
                begin
                    dec_op   = OP_WRITE;
                    dec_tgt  = req.position;
                    dec_read = 1'b1;
                end
            end
            CMD_READ:
            begin
                if (req.position >= count_reg)
                    dec_status = STS_RANGE;
                else
                begin
                    dec_tgt  = req.position;
                    dec_read = 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                dec_op = OP_CLEAR;
            end
            default:
            begin
                dec_op = OP_HOLD;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        walk_next   = walk_reg;
        ctl         = '{op: OP_HOLD, capture: 1'b0, shift: 1'b0};
        req.ready   = 1'b0;
        load_rsp    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                    state_next = S_APPLY;
            end
            S_APPLY:
            begin
                ctl.op      = op_reg;
                ctl.capture = 1'b1;
                walk_next   = tgt_reg;
                case (op_reg)
                    OP_INSERT: count_next = count_reg + 1'b1;
                    OP_REMOVE: count_next = count_reg - 1'b1;
                    OP_CLEAR:  count_next = '0;
                    default:   count_next = count_reg;
                endcase
                if (read_reg && (tgt_reg != '0))
                    state_next = S_WALK;
                else
                    state_next = S_DONE;
            end
            S_WALK:
            begin
                ctl.shift = 1'b1;
                walk_next = walk_reg - 1'b1;
                if (walk_reg == IDX_W'(1))
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    load_rsp   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_rsp)
            rsp_valid_next = 1'b1;
        else if (rsp.ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            walk_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            walk_reg      <= walk_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= dec_op;
            status_reg <= dec_status;
            tgt_reg    <= dec_tgt;
            value_reg  <= req.value_in;
            read_reg   <= dec_read;
        end
        if (load_rsp)
        begin
            rsp_value_reg  <= read_reg ? rd_head : '0;
            rsp_status_reg <= status_reg;
            rsp_count_reg  <= count_reg;
        end
    end

    assign tgt           = tgt_reg;
    assign wr_value      = value_reg;
    assign rsp.valid     = rsp_valid_reg;
    assign rsp.value_out = rsp_value_reg;
    assign rsp.status    = rsp_status_reg;
    assign rsp.count     = rsp_count_reg;

endmodule

@@ sim/tb_array_linked_list_with_free_list.sv @@
// ----------------------------------------------------------------------------
// tb_array_linked_list_with_free_list: self-checking bench for the list block
// A short scripted sequence opens the run and covers the empty and
// out-of-range cases, the field extremes and the unused command codes. Long
// random runs follow, with a mix that grows, holds or shrinks the list.
// Every command is fed to a queue-based model of the positional list. Each
// response is compared field by field with the oldest predicted response.
// ----------------------------------------------------------------------------
module tb_array_linked_list_with_free_list;

    import alfl_pkg::*;

    localparam int DEPTH        = CAPACITY_DEF;
    localparam int DW           = DATA_WIDTH_DEF;
    localparam int PW           = IDX_WIDTH_DEF;
    localparam int SCRIPT_LEN   = 25;
    localparam int LONG_HOLD    = 400;   // receiver back-pressure stretch
    localparam int DRAIN_CYCLES = 80;    // beyond the worst command latency
    localparam int STALL_LIMIT  = 3000;  // cycles with no transaction at all

    // Command codes that the block must ignore.
    localparam logic [CMD_WIDTH-1:0] CMD_UNDEF_LO = 4'd9;
    localparam logic [CMD_WIDTH-1:0] CMD_UNDEF_HI = 4'd15;

    // Shape of the random command mix.
    typedef enum logic [1:0] {
        MIX_GROW,
        MIX_EVEN,
        MIX_SHRINK
    } mix_t;

    // One response: element, status and count after the command.
    typedef struct packed {
        logic signed [DW-1:0] value;
        status_t              status;
        logic [PW-1:0]        count;
    } list_rsp_t;

    // One row of the scripted sequence. When known is set, the response is
    // taken from the row itself instead of from the list model.
    typedef struct packed {
        logic [CMD_WIDTH-1:0] op;
        logic [PW-1:0]        pos;
        logic signed [DW-1:0] val;
        logic                 known;
        list_rsp_t            want;
    } script_row_t;

    logic clk;
    logic rst_n;

    alfl_req_if req_ch ();
    alfl_rsp_if rsp_ch ();

    array_linked_list_with_free_list DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Model state: the list contents front to back.
    logic signed [DW-1:0] list_q [$];
    // Responses that are still due, oldest first.
    list_rsp_t pending_rsp [$];

    int send_idle_pct;
    int recv_stall_pct;
    bit long_hold_req;
    int errors;
    int cmds_sent;
    int rsps_checked;
    int peak_len;
    int status_hits [4];

    // The scripted opening. The list goes from empty to five elements and
    // back to empty. The rows left untyped are checked against the model.
    script_row_t script [SCRIPT_LEN] = '{
        '{CMD_POP_FRONT,  7'd0,   32'sd0,           1'b1, '{32'sd0, STS_EMPTY, 7'd0}},
        '{CMD_POP_BACK,   7'd0,   32'sd0,           1'b1, '{32'sd0, STS_EMPTY, 7'd0}},
        '{CMD_READ,       7'd0,   32'sd0,           1'b1, '{32'sd0, STS_RANGE, 7'd0}},
        '{CMD_REMOVE,     7'd0,   32'sd0,           1'b1, '{32'sd0, STS_RANGE, 7'd0}},
        '{CMD_REPLACE,    7'd0,   32'sh12345678,    1'b1, '{32'sd0, STS_RANGE, 7'd0}},
        '{CMD_INSERT,     7'd1,   32'sd5,           1'b1, '{32'sd0, STS_RANGE, 7'd0}},
        '{CMD_CLEAR,      7'd0,   32'sd0,           1'b1, '{32'sd0, STS_OK,    7'd0}},
        '{CMD_INSERT,     7'd0,   32'sh7FFFFFFF,    1'b1, '{32'sd0, STS_OK,    7'd1}},
        '{CMD_PUSH_BACK,  7'd0,   32'sh80000000,    1'b1, '{32'sd0, STS_OK,    7'd2}},
        '{CMD_PUSH_FRONT, 7'd0,   -32'sd1,          1'b1, '{32'sd0, STS_OK,    7'd3}},
        '{CMD_INSERT,     7'd3,   32'sd0,           1'b1, '{32'sd0, STS_OK,    7'd4}},
        '{CMD_READ,       7'd0,   32'sd0,           1'b1, '{-32'sd1, STS_OK,   7'd4}},
        '{CMD_READ,       7'd3,   32'sd0,           1'b1, '{32'sd0, STS_OK,    7'd4}},
        '{CMD_READ,       7'd4,   32'sd0,           1'b1, '{32'sd0, STS_RANGE, 7'd4}},
        '{CMD_REPLACE,    7'd1,   32'sh5A5A5A5A,    1'b1,
          '{32'sh7FFFFFFF, STS_OK, 7'd4}},
        '{CMD_INSERT,     7'd2,   32'sh2468ACE0,    1'b0, '0},
        '{CMD_REMOVE,     7'd3,   32'sd0,           1'b0, '0},
        '{CMD_POP_BACK,   7'd0,   32'sd0,           1'b0, '0},
        '{CMD_POP_FRONT,  7'd0,   32'sd0,           1'b0, '0},
        '{CMD_UNDEF_HI,   7'd127, -32'sd1,          1'b1, '{32'sd0, STS_OK,    7'd2}},
        '{CMD_READ,       7'd127, 32'sd0,           1'b1, '{32'sd0, STS_RANGE, 7'd2}},
        '{CMD_INSERT,     7'd127, 32'sd9,           1'b1, '{32'sd0, STS_RANGE, 7'd2}},
        '{CMD_REMOVE,     7'd2,   32'sd0,           1'b1, '{32'sd0, STS_RANGE, 7'd2}},
        '{CMD_CLEAR,      7'd0,   32'sd0,           1'b1, '{32'sd0, STS_OK,    7'd0}},
        '{CMD_UNDEF_LO,   7'd64,  32'sd0,           1'b1, '{32'sd0, STS_OK,    7'd0}}
    };

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // List model
    // ------------------------------------------------------------------------
    // Applies one command to the list and returns the response that the
    // block owes for it. The list is full when it holds DEPTH elements. An
    // insert checks its position before it checks for room, so an insert
    // past the end of a full list reports a range error.
    function automatic list_rsp_t apply_to_list(input logic [CMD_WIDTH-1:0] op,
                                                input logic [PW-1:0] pos,
                                                input logic signed [DW-1:0] val);
        list_rsp_t r;
        int        len;
        int        at;
        r        = '0;
        r.status = STS_OK;
        len      = list_q.size();
        at       = (op == CMD_PUSH_FRONT) ? 0 : int'(pos);
        case (op)
            CMD_INSERT, CMD_PUSH_FRONT:
            begin
                if (at > len)
                    r.status = STS_RANGE;
                else if (len == DEPTH)
                    r.status = STS_FULL;
                else
                    list_q.insert(at, val);
            end
            CMD_PUSH_BACK:
            begin
                if (len == DEPTH)
                    r.status = STS_FULL;
                else
                    list_q.insert(len, val);
            end
            CMD_POP_FRONT:
            begin
                if (len == 0)
                    r.status = STS_EMPTY;
                else
                begin
                    r.value = list_q[0];
                    list_q.delete(0);
                end
            end
            CMD_POP_BACK:
            begin
                if (len == 0)
                    r.status = STS_EMPTY;
                else
                begin
                    r.value = list_q[len - 1];
                    list_q.delete(len - 1);
                end
            end
            CMD_REMOVE:
            begin
                if (at >= len)
                    r.status = STS_RANGE;
                else
                begin
                    r.value = list_q[at];
                    list_q.delete(at);
                end
            end
            CMD_REPLACE, CMD_READ:
            begin
                if (at >= len)
                    r.status = STS_RANGE;
                else
                begin
                    r.value = list_q[at];
                    if (op == CMD_REPLACE)
                        list_q[at] = val;
                end
            end
            CMD_CLEAR:
                list_q.delete();
            default:
                ;
        endcase
        r.count = PW'(list_q.size());
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------------
    // Offers one command, possibly after idling at random, and waits for the
    // transaction. The model runs at the edge where the command is taken.
    // Valid is written at most once per time step: either it is lowered for
    // an idle cycle, or it stays high and the payload changes.
    task automatic send_cmd(input logic [CMD_WIDTH-1:0] op, input logic [PW-1:0] pos,
                            input logic signed [DW-1:0] val, input logic known,
                            input list_rsp_t want);
        list_rsp_t pred;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.cmd      <= op;
        req_ch.position <= pos;
        req_ch.value_in <= val;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pred = apply_to_list(op, pos, val);
        pending_rsp.insert(pending_rsp.size(), known ? want : pred);
        status_hits[pred.status]++;
        cmds_sent++;
        if (list_q.size() > peak_len)
            peak_len = list_q.size();
    endtask

    function automatic logic signed [DW-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh7FFFFFFF;
            1:       return 32'sh80000000;
            2:       return 32'sd0;
            3:       return -32'sd1;
            default: return $urandom();
        endcase
    endfunction

    // Command choice by mix. Growing leaves out clear so that the list
    // reaches its capacity and the full status shows up; shrinking drives it
    // to empty so that pops on an empty list happen.
    function automatic logic [CMD_WIDTH-1:0] pick_cmd(input mix_t mix);
        int roll;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_GROW:
            begin
                if (roll < 25)      return CMD_INSERT;
                else if (roll < 45) return CMD_PUSH_BACK;
                else if (roll < 60) return CMD_PUSH_FRONT;
                else if (roll < 66) return CMD_POP_FRONT;
                else if (roll < 72) return CMD_POP_BACK;
                else if (roll < 78) return CMD_REMOVE;
                else if (roll < 86) return CMD_REPLACE;
                else if (roll < 97) return CMD_READ;
            end
            MIX_SHRINK:
            begin
                if (roll < 6)       return CMD_INSERT;
                else if (roll < 10) return CMD_PUSH_BACK;
                else if (roll < 14) return CMD_PUSH_FRONT;
                else if (roll < 32) return CMD_POP_FRONT;
                else if (roll < 50) return CMD_POP_BACK;
                else if (roll < 72) return CMD_REMOVE;
                else if (roll < 80) return CMD_REPLACE;
                else if (roll < 92) return CMD_READ;
                else if (roll < 94) return CMD_CLEAR;
            end
            default:
            begin
                if (roll < 14)      return CMD_INSERT;
                else if (roll < 25) return CMD_PUSH_BACK;
                else if (roll < 36) return CMD_PUSH_FRONT;
                else if (roll < 45) return CMD_POP_FRONT;
                else if (roll < 54) return CMD_POP_BACK;
                else if (roll < 65) return CMD_REMOVE;
                else if (roll < 77) return CMD_REPLACE;
                else if (roll < 93) return CMD_READ;
                else if (roll < 95) return CMD_CLEAR;
            end
        endcase
        return CMD_WIDTH'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI));
    endfunction

    // Mostly legal positions for the current length, with one in ten drawn
    // over the whole field so that the range checks and the top bit are hit.
    task automatic run_random(input mix_t mix, input int n_cmds);
        logic [CMD_WIDTH-1:0] op;
        logic [PW-1:0]        pos;
        int                   len;
        for (int i = 0; i < n_cmds; i++)
        begin
            op  = pick_cmd(mix);
            len = list_q.size();
            if ($urandom_range(0, 9) == 0)
                pos = PW'($urandom_range(0, 127));
            else if (op == CMD_INSERT)
                pos = PW'($urandom_range(0, len));
            else
                pos = (len == 0) ? '0 : PW'($urandom_range(0, len - 1));
            send_cmd(op, pos, pick_value(), 1'b0, '0);
        end
        req_ch.valid <= 1'b0;
    endtask

    // Holds the command side until every response owed has come back.
    task automatic wait_drained();
        while (pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Response side
    // ------------------------------------------------------------------------
    // Samples each response transaction at the clock edge and compares it
    // with the oldest prediction. Ready for the next cycle is chosen here:
    // held low for a long stretch on request, otherwise low at random.
    initial
    begin
        int        hold_left;
        list_rsp_t exp_rsp;
        hold_left    = 0;
        rsp_ch.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_rsp.size() == 0)
                begin
                    $display("%0t: response with nothing outstanding: value %h status %0d count %0d",
                             $time, rsp_ch.value_out, rsp_ch.status, rsp_ch.count);
                    errors++;
                end
                else
                begin
                    exp_rsp = pending_rsp[0];
                    pending_rsp.delete(0);
                    rsps_checked++;
                    if (rsp_ch.value_out !== exp_rsp.value)
                    begin
                        $display("%0t: value_out expected %h actual %h",
                                 $time, exp_rsp.value, rsp_ch.value_out);
                        errors++;
                    end
                    if (rsp_ch.status !== exp_rsp.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_rsp.status, rsp_ch.status);
                        errors++;
                    end
                    if (rsp_ch.count !== exp_rsp.count)
                    begin
                        $display("%0t: count expected %0d actual %0d",
                                 $time, exp_rsp.count, rsp_ch.count);
                        errors++;
                    end
                end
            end
            if (long_hold_req)
            begin
                hold_left     = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    // Counts cycles in which neither channel moves a transaction. The longest
    // legal quiet stretch is the long receiver hold plus the latency of a command.
    initial
    begin
        int quiet;
        quiet = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles, %0d responses outstanding",
                         $time, quiet, pending_rsp.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        errors          = 0;
        cmds_sent       = 0;
        rsps_checked    = 0;
        peak_len        = 0;
        status_hits     = '{0, 0, 0, 0};
        long_hold_req   = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.cmd      <= CMD_INSERT;
        req_ch.position <= '0;
        req_ch.value_in <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Scripted opening, back to back with a free-running receiver.
        for (int i = 0; i < SCRIPT_LEN; i++)
            send_cmd(script[i].op, script[i].pos, script[i].val,
                     script[i].known, script[i].want);
        req_ch.valid <= 1'b0;
        wait_drained();

        // No idling on either side while the list fills up to capacity and
        // then sees inserts and pushes refused for lack of room.
        run_random(MIX_GROW, 200);
        wait_drained();

        // Sparse commands against an eager receiver.
        send_idle_pct = 82;
        run_random(MIX_EVEN, 110);
        wait_drained();

        // Eager sender against a slow receiver, emptying the list.
        send_idle_pct  = 0;
        recv_stall_pct = 82;
        run_random(MIX_SHRINK, 120);
        wait_drained();

        // The receiver stops for a long stretch while commands keep coming,
        // so the output register and the sequencer both fill and the block
        // must hold its command input off.
        recv_stall_pct = 0;
        long_hold_req  = 1'b1;
        run_random(MIX_EVEN, 24);
        wait_drained();

        // Light idling on both sides.
        send_idle_pct  = 15;
        recv_stall_pct = 15;
        run_random(MIX_EVEN, 180);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d commands, checked %0d responses, longest list %0d of %0d.",
                 cmds_sent, rsps_checked, peak_len, DEPTH);
        $display("Status seen: ok %0d, range %0d, empty %0d, full %0d.",
                 status_hits[STS_OK], status_hits[STS_RANGE],
                 status_hits[STS_EMPTY], status_hits[STS_FULL]);
        if (errors == 0 && pending_rsp.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
